// ===== rtl/tcld_pkg.sv =====
// Package for the terminal canonical line discipline.
// Holds store sizing, register map, character codes and shared types.
// No dependencies.
package tcld_pkg;

  localparam int StoreDepth = 1024;
  localparam int PtrW       = $clog2(StoreDepth);

  localparam int CfgNum   = 8;
  localparam int CfgAddrW = $clog2(CfgNum) + 2;

  typedef enum logic [$clog2(CfgNum)-1:0] {
    RegMode  = 3'd0,
    RegKill  = 3'd1,
    RegErase = 3'd2,
    RegEof   = 3'd3,
    RegStop  = 3'd4,
    RegStart = 3'd5,
    RegIntr  = 3'd6,
    RegQuit  = 3'd7
  } tcld_reg_e;

  localparam logic [7:0] CfgReset [CfgNum] = '{
    8'd241, 8'd21, 8'd127, 8'd4, 8'd19, 8'd17, 8'd3, 8'd28
  };

  // mode flag bit positions
  localparam int FlagCrToNl   = 0;
  localparam int FlagDropCr   = 1;
  localparam int FlagNlToCr   = 2;
  localparam int FlagLower    = 3;
  localparam int FlagCanon    = 4;
  localparam int FlagSignals  = 5;
  localparam int FlagEcho     = 6;
  localparam int FlagEchoCtl  = 7;

  localparam logic [7:0] CharCr      = 8'd13;
  localparam logic [7:0] CharNl      = 8'd10;
  localparam logic [7:0] CharCaret   = 8'h5E;
  localparam logic [7:0] CharUpperA  = 8'h41;
  localparam logic [7:0] CharUpperZ  = 8'h5A;
  localparam logic [7:0] CaseOffset  = 8'd32;
  localparam logic [7:0] CtlLimit    = 8'd32;
  localparam logic [7:0] CaretOffset = 8'd64;

  typedef enum logic {
    OpRaw  = 1'b0,
    OpTake = 1'b1
  } tcld_op_e;

  typedef enum logic [1:0] {
    SigNone = 2'd0,
    SigIntr = 2'd1,
    SigQuit = 2'd2
  } tcld_sig_e;

  typedef enum logic [2:0] {
    StIdle,
    StExec,
    StReadWait,
    StEraseRd,
    StEraseChk,
    StFinish
  } tcld_state_e;

  typedef struct packed {
    logic [7:0] mode_flags;
    logic [7:0] kill_key;
    logic [7:0] erase_key;
    logic [7:0] eof_key;
    logic [7:0] stop_key;
    logic [7:0] start_key;
    logic [7:0] intr_key;
    logic [7:0] quit_key;
  } tcld_cfg_t;

endpackage

// ===== rtl/tcld_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module tcld_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/tcld_regs.sv =====
// APB configuration registers of the line discipline.
// Depends on tcld_pkg.
module tcld_regs
  import tcld_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output tcld_cfg_t           cfg_o
);

  logic [7:0]        regs_q [CfgNum];
  logic [7:0]        regs_d [CfgNum];
  logic [CfgAddrW-3:0] idx;

  assign idx    = paddr[CfgAddrW-1:2];
  assign pready = 1'b1;
  assign prdata = {24'd0, regs_q[idx]};

  always_comb begin
    regs_d = regs_q;
    if (psel && penable && pwrite) begin
      regs_d[idx] = pwdata[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q <= CfgReset;
    end else begin
      regs_q <= regs_d;
    end
  end

  assign cfg_o.mode_flags = regs_q[RegMode];
  assign cfg_o.kill_key   = regs_q[RegKill];
  assign cfg_o.erase_key  = regs_q[RegErase];
  assign cfg_o.eof_key    = regs_q[RegEof];
  assign cfg_o.stop_key   = regs_q[RegStop];
  assign cfg_o.start_key  = regs_q[RegStart];
  assign cfg_o.intr_key   = regs_q[RegIntr];
  assign cfg_o.quit_key   = regs_q[RegQuit];

endmodule

// ===== rtl/tcld_ctrl.sv =====
// Sequencer of the line discipline: translation, edit keys, ring pointers,
// store read-modify-write and the output word register.
// Depends on tcld_pkg; drives the ports of one tcld_ram.
module tcld_ctrl
  import tcld_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tcld_cfg_t       cfg_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            operation_i,
  input  logic [7:0]      raw_byte_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic            accepted_o,
  output logic [1:0]      echo_count_o,
  output logic [7:0]      echo_first_o,
  output logic [7:0]      echo_second_o,
  output logic [10:0]     rubout_count_o,
  output logic [1:0]      signal_kind_o,
  output logic            stored_o,
  output logic            stopped_now_o,
  output logic            read_valid_o,
  output logic [7:0]      read_byte_o,
  output logic [9:0]      store_level_o,
  output logic            ram_we_o,
  output logic [PtrW-1:0] ram_waddr_o,
  output logic [7:0]      ram_wdata_o,
  output logic [PtrW-1:0] ram_raddr_o,
  input  logic [7:0]      ram_rdata_i
);

  localparam logic [PtrW-1:0] PtrMax = PtrW'(StoreDepth - 1);
  localparam logic [PtrW:0]   DepthW = (PtrW+1)'(StoreDepth);

  tcld_state_e state_q, state_d;

  logic            op_q, op_d;
  logic [7:0]      c_q, c_d;
  logic            drop_q, drop_d;
  logic            kill_q, kill_d;
  logic [PtrW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic            stopped_q, stopped_d;
  logic [10:0]     rub_q, rub_d;
  logic            acc_q, acc_d;
  logic [1:0]      ecnt_q, ecnt_d;
  logic [7:0]      e1_q, e1_d, e2_q, e2_d;
  logic [1:0]      sig_q, sig_d;
  logic            st_q, st_d;
  logic            rv_q, rv_d;
  logic [7:0]      rb_q, rb_d;

  logic            ov_q, ov_d;
  logic            o_acc_q, o_acc_d;
  logic [1:0]      o_ecnt_q, o_ecnt_d;
  logic [7:0]      o_e1_q, o_e1_d, o_e2_q, o_e2_d;
  logic [10:0]     o_rub_q, o_rub_d;
  logic [1:0]      o_sig_q, o_sig_d;
  logic            o_st_q, o_st_d;
  logic            o_stop_q, o_stop_d;
  logic            o_rv_q, o_rv_d;
  logic [7:0]      o_rb_q, o_rb_d;
  logic [9:0]      o_lvl_q, o_lvl_d;

  logic [PtrW:0]   lvl_wide;
  logic [PtrW-1:0] level;
  logic [PtrW-1:0] wp_prev, wp_next, rp_next;
  logic [7:0]      xlat;
  logic            xlat_drop;
  logic [7:0]      mf;
  logic            canon, sigs;

  assign mf    = cfg_i.mode_flags;
  assign canon = mf[FlagCanon];
  assign sigs  = mf[FlagSignals];

  assign lvl_wide = {1'b0, wp_q} + DepthW - {1'b0, rp_q};
  assign level    = (wp_q >= rp_q) ? (wp_q - rp_q) : lvl_wide[PtrW-1:0];
  assign wp_prev  = (wp_q == '0) ? PtrMax : wp_q - 1'b1;
  assign wp_next  = (wp_q == PtrMax) ? '0 : wp_q + 1'b1;
  assign rp_next  = (rp_q == PtrMax) ? '0 : rp_q + 1'b1;

  // input translation
  always_comb begin
    xlat      = raw_byte_i;
    xlat_drop = 1'b0;
    if (raw_byte_i == CharCr) begin
      if (mf[FlagCrToNl]) begin
        xlat = CharNl;
      end else if (mf[FlagDropCr]) begin
        xlat_drop = 1'b1;
      end
    end else if (raw_byte_i == CharNl && mf[FlagNlToCr]) begin
      xlat = CharCr;
    end
    if (!xlat_drop && mf[FlagLower] && xlat >= CharUpperA && xlat <= CharUpperZ) begin
      xlat = xlat + CaseOffset;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign ram_raddr_o = (state_q == StExec) ? rp_q : wp_prev;
  assign ram_waddr_o = wp_q;
  assign ram_wdata_o = c_q;

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    c_d       = c_q;
    drop_d    = drop_q;
    kill_d    = kill_q;
    wp_d      = wp_q;
    rp_d      = rp_q;
    stopped_d = stopped_q;
    rub_d     = rub_q;
    acc_d     = acc_q;
    ecnt_d    = ecnt_q;
    e1_d      = e1_q;
    e2_d      = e2_q;
    sig_d     = sig_q;
    st_d      = st_q;
    rv_d      = rv_q;
    rb_d      = rb_q;
    ram_we_o  = 1'b0;

    ov_d     = ov_q && !out_ready_i;
    o_acc_d  = o_acc_q;
    o_ecnt_d = o_ecnt_q;
    o_e1_d   = o_e1_q;
    o_e2_d   = o_e2_q;
    o_rub_d  = o_rub_q;
    o_sig_d  = o_sig_q;
    o_st_d   = o_st_q;
    o_stop_d = o_stop_q;
    o_rv_d   = o_rv_q;
    o_rb_d   = o_rb_q;
    o_lvl_d  = o_lvl_q;

    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          op_d    = operation_i;
          c_d     = xlat;
          drop_d  = xlat_drop;
          kill_d  = 1'b0;
          rub_d   = '0;
          acc_d   = 1'b0;
          ecnt_d  = '0;
          e1_d    = '0;
          e2_d    = '0;
          sig_d   = SigNone;
          st_d    = 1'b0;
          rv_d    = 1'b0;
          rb_d    = '0;
          state_d = StExec;
        end
      end
      StExec: begin
        state_d = StFinish;
        if (op_q == OpTake) begin
          if (wp_q != rp_q) begin
            rp_d    = rp_next;
            rv_d    = 1'b1;
            state_d = StReadWait;
          end
        end else if (level != PtrMax) begin
          acc_d = 1'b1;
          if (drop_q) begin
            state_d = StFinish;
          end else if (canon && c_q == cfg_i.kill_key) begin
            kill_d  = 1'b1;
            state_d = StEraseRd;
          end else if (canon && c_q == cfg_i.erase_key) begin
            state_d = StEraseRd;
          end else if (canon && c_q == cfg_i.stop_key) begin
            stopped_d = 1'b1;
          end else if (canon && c_q == cfg_i.start_key) begin
            stopped_d = 1'b0;
          end else if (sigs && c_q == cfg_i.intr_key) begin
            sig_d = SigIntr;
          end else if (sigs && c_q == cfg_i.quit_key) begin
            sig_d = SigQuit;
          end else begin
            if (mf[FlagEcho]) begin
              if (c_q == CharNl) begin
                ecnt_d = 2'd2;
                e1_d   = CharNl;
                e2_d   = CharCr;
              end else if (c_q < CtlLimit) begin
                if (mf[FlagEchoCtl]) begin
                  ecnt_d = 2'd2;
                  e1_d   = CharCaret;
                  e2_d   = c_q + CaretOffset;
                end
              end else begin
                ecnt_d = 2'd1;
                e1_d   = c_q;
              end
            end
            ram_we_o = 1'b1;
            wp_d     = wp_next;
            st_d     = 1'b1;
          end
        end
      end
      StReadWait: begin
        rb_d    = ram_rdata_i;
        state_d = StFinish;
      end
      StEraseRd: begin
        state_d = (wp_q == rp_q) ? StFinish : StEraseChk;
      end
      StEraseChk: begin
        if (ram_rdata_i == CharNl || ram_rdata_i == cfg_i.eof_key) begin
          state_d = StFinish;
        end else begin
          wp_d = wp_prev;
          if (mf[FlagEcho]) begin
            rub_d = rub_q + ((ram_rdata_i < CtlLimit) ? 11'd2 : 11'd1);
          end
          state_d = kill_q ? StEraseRd : StFinish;
        end
      end
      StFinish: begin
        if (!ov_q || out_ready_i) begin
          ov_d     = 1'b1;
          o_acc_d  = acc_q;
          o_ecnt_d = ecnt_q;
          o_e1_d   = e1_q;
          o_e2_d   = e2_q;
          o_rub_d  = rub_q;
          o_sig_d  = sig_q;
          o_st_d   = st_q;
          o_stop_d = stopped_q;
          o_rv_d   = rv_q;
          o_rb_d   = rb_q;
          o_lvl_d  = 10'(level);
          state_d  = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      wp_q      <= '0;
      rp_q      <= '0;
      stopped_q <= 1'b0;
      ov_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      wp_q      <= wp_d;
      rp_q      <= rp_d;
      stopped_q <= stopped_d;
      ov_q      <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    c_q      <= c_d;
    drop_q   <= drop_d;
    kill_q   <= kill_d;
    rub_q    <= rub_d;
    acc_q    <= acc_d;
    ecnt_q   <= ecnt_d;
    e1_q     <= e1_d;
    e2_q     <= e2_d;
    sig_q    <= sig_d;
    st_q     <= st_d;
    rv_q     <= rv_d;
    rb_q     <= rb_d;
    o_acc_q  <= o_acc_d;
    o_ecnt_q <= o_ecnt_d;
    o_e1_q   <= o_e1_d;
    o_e2_q   <= o_e2_d;
    o_rub_q  <= o_rub_d;
    o_sig_q  <= o_sig_d;
    o_st_q   <= o_st_d;
    o_stop_q <= o_stop_d;
    o_rv_q   <= o_rv_d;
    o_rb_q   <= o_rb_d;
    o_lvl_q  <= o_lvl_d;
  end

  assign out_valid_o    = ov_q;
  assign accepted_o     = o_acc_q;
  assign echo_count_o   = o_ecnt_q;
  assign echo_first_o   = o_e1_q;
  assign echo_second_o  = o_e2_q;
  assign rubout_count_o = o_rub_q;
  assign signal_kind_o  = o_sig_q;
  assign stored_o       = o_st_q;
  assign stopped_now_o  = o_stop_q;
  assign read_valid_o   = o_rv_q;
  assign read_byte_o    = o_rb_q;
  assign store_level_o  = o_lvl_q;

  a_load_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ov_q) |-> $past(state_q == StFinish))
    else $error("output word loaded outside finish");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == StExec))
    else $error("accepted word did not start execution");

  a_stored_accepted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && (o_st_q || o_sig_q != SigNone)) |-> (o_acc_q && !o_rv_q))
    else $error("stored or signal result without accepted byte");

  a_take_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StReadWait) |-> $past(wp_q != rp_q))
    else $error("take read issued on empty store");

  a_store_write_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o |-> (level != PtrMax))
    else $error("store written while full");

endmodule

// ===== rtl/tty_canonical_line_discipline.sv =====
// Terminal canonical line discipline, top level.
// Usage:
//   Input channel (in_valid_i/in_ready_o): one word per step, operation_i
//   selects a raw byte arrival (raw_byte_i) or a take of one cooked byte.
//   Output channel (out_valid_o/out_ready_i): exactly one result word per
//   input word, in order, held in an output register.
//   Config: APB registers mode_flags, kill, erase, eof, stop, start, intr,
//   quit at byte addresses 0..28; write only while the block is idle.
// Timing: one word at a time: exec, then read wait for a take that returns
//   a byte, then finish, which loads the output register; the next word is
//   accepted once the sequencer is idle again. An erase adds a read state
//   and a check state (only the read on an empty store); a kill repeats
//   them per character removed, bounded by the line length. The store RAM
//   has one read and one write port with a registered read; each erase
//   step is a read then a compare.
// Reset: pointers, stopped flag and registers go to their reset values;
//   the store is empty and needs no clearing pass.
// Stall: if the output register is still full, the finished result waits
//   in the sequencer and no new word is accepted until it moves out.
// Depends on tcld_pkg, tcld_regs, tcld_ctrl, tcld_ram.
module tty_canonical_line_discipline
  import tcld_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                operation_i,
  input  logic [7:0]          raw_byte_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                accepted_o,
  output logic [1:0]          echo_count_o,
  output logic [7:0]          echo_first_o,
  output logic [7:0]          echo_second_o,
  output logic [10:0]         rubout_count_o,
  output logic [1:0]          signal_kind_o,
  output logic                stored_o,
  output logic                stopped_now_o,
  output logic                read_valid_o,
  output logic [7:0]          read_byte_o,
  output logic [9:0]          store_level_o
);

  tcld_cfg_t       cfg;
  logic            ram_we;
  logic [PtrW-1:0] ram_waddr, ram_raddr;
  logic [7:0]      ram_wdata, ram_rdata;

  tcld_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tcld_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .raw_byte_i     (raw_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .accepted_o     (accepted_o),
    .echo_count_o   (echo_count_o),
    .echo_first_o   (echo_first_o),
    .echo_second_o  (echo_second_o),
    .rubout_count_o (rubout_count_o),
    .signal_kind_o  (signal_kind_o),
    .stored_o       (stored_o),
    .stopped_now_o  (stopped_now_o),
    .read_valid_o   (read_valid_o),
    .read_byte_o    (read_byte_o),
    .store_level_o  (store_level_o),
    .ram_we_o       (ram_we),
    .ram_waddr_o    (ram_waddr),
    .ram_wdata_o    (ram_wdata),
    .ram_raddr_o    (ram_raddr),
    .ram_rdata_i    (ram_rdata)
  );

  tcld_ram #(
    .Width (8),
    .Depth (StoreDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule
